### hdl/tcgg_pkg.sv
// Package for the three color gradient generator: defaults, types, codes and helpers.
`timescale 1ns / 1ps

package tcgg_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int MAX_HEIGHT_DEF    = 4096;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SIZE_REG_W  = 13;
    localparam int COLOR_W     = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [SIZE_REG_W-1:0] WIDTH_RESET  = 13'd500;
    localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET = 13'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COLOR_LEFT   = 3'd2,
        CFG_COLOR_MIDDLE = 3'd3,
        CFG_COLOR_RIGHT  = 3'd4
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DSTART,
        ST_DWAIT,
        ST_PIX
    } t_state;

    // channel 0 is red (bits 23:16), 1 green, 2 blue
    function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] color,
                                               input logic [1:0] idx);
        logic [CHAN_W-1:0] res;
        case (idx)
            2'd0:    res = color[23:16];
            2'd1:    res = color[15:8];
            default: res = color[7:0];
        endcase
        return res;
    endfunction

endpackage

### hdl/tcgg_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tcgg_divider #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = ~diff[DVS_W];
        n_rem = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hdl/three_color_gradient_generator.sv
// Top level of the three color gradient generator.
`timescale 1ns / 1ps

// Emits one RGB pixel per request in raster order, ramping left->middle over the
// first floor(W/2) columns and middle->right over the rest, with row_end and
// frame_end flags. An ordinary pixel is accepted in ST_IDLE, then accumulated
// and registered in ST_PIX. The first pixel of a frame also computes the six ramp
// steps on one shared restoring divider, one quotient bit per cycle. The output
// register lets the next request be taken while a pixel still waits. Register
// writes apply to the steps at the next frame start; colors are read at each
// part start.

module three_color_gradient_generator #(
    parameter int MAX_WIDTH     = tcgg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = tcgg_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = tcgg_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tcgg_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [tcgg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_restart,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [tcgg_pkg::CHAN_W-1:0]            o_red,
    output logic [tcgg_pkg::CHAN_W-1:0]            o_green,
    output logic [tcgg_pkg::CHAN_W-1:0]            o_blue,
    output logic                                   o_row_end,
    output logic                                   o_frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = tcgg_pkg::CHAN_W + FRACTION_BITS;
    localparam int SW = AW + 1;
    localparam int NC = tcgg_pkg::NUM_CHAN;

    // configuration
    logic [tcgg_pkg::SIZE_REG_W-1:0] r_image_width;
    logic [tcgg_pkg::SIZE_REG_W-1:0] r_image_height;
    logic [tcgg_pkg::COLOR_W-1:0]    r_color_left;
    logic [tcgg_pkg::COLOR_W-1:0]    r_color_middle;
    logic [tcgg_pkg::COLOR_W-1:0]    r_color_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= tcgg_pkg::WIDTH_RESET;
            r_image_height <= tcgg_pkg::HEIGHT_RESET;
            r_color_left   <= '0;
            r_color_middle <= '0;
            r_color_right  <= '0;
        end else if (i_cfg_we) begin
            unique case (tcgg_pkg::t_cfg_index'(i_cfg_index))
                tcgg_pkg::CFG_IMAGE_WIDTH:
                    r_image_width  <= i_cfg_data[tcgg_pkg::SIZE_REG_W-1:0];
                tcgg_pkg::CFG_IMAGE_HEIGHT:
                    r_image_height <= i_cfg_data[tcgg_pkg::SIZE_REG_W-1:0];
                tcgg_pkg::CFG_COLOR_LEFT:   r_color_left   <= i_cfg_data;
                tcgg_pkg::CFG_COLOR_MIDDLE: r_color_middle <= i_cfg_data;
                tcgg_pkg::CFG_COLOR_RIGHT:  r_color_right  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [31:0]   w_full;
    logic [31:0]   h_full;
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [WW-1:0] split;
    logic [WW-1:0] right_len;

    always_comb begin
        if (r_image_width == '0) begin
            w_full = 32'd1;
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_full = 32'd1;
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end else begin
            h_full = 32'(r_image_height);
        end
        w         = w_full[WW-1:0];
        h         = h_full[HW-1:0];
        split     = w >> 1;
        right_len = w - split;
    end

    // state
    tcgg_pkg::t_state        r_state;
    tcgg_pkg::t_state        n_state;
    logic [CW-1:0]           r_col;
    logic [HW-1:0]           r_row;
    logic [2:0]              r_k;
    logic [AW-1:0]           r_acc    [NC];
    logic signed [SW-1:0]    r_step_l [NC];
    logic signed [SW-1:0]    r_step_r [NC];
    logic                    r_o_valid;
    logic [tcgg_pkg::CHAN_W-1:0] r_red;
    logic [tcgg_pkg::CHAN_W-1:0] r_green;
    logic [tcgg_pkg::CHAN_W-1:0] r_blue;
    logic                    r_row_end;
    logic                    r_frame_end;

    logic in_fire;
    logic pix_fire;
    logic div_start;

    // position after restart and wrap
    logic [WW-1:0] c_col;
    logic [HW:0]   c_row;
    logic          frame_start;

    always_comb begin
        c_col = i_restart ? '0 : WW'(r_col);
        c_row = i_restart ? '0 : (HW+1)'(r_row);
        if (c_col >= w) begin
            c_col = '0;
            c_row = c_row + (HW+1)'(1);
        end
        if (c_row >= {1'b0, h}) begin
            c_row = '0;
        end
        frame_start = (c_col == '0) && (c_row == '0);
    end

    // step operands
    logic [1:0]                  ch;
    logic                        is_right_k;
    logic [tcgg_pkg::CHAN_W-1:0] from_c;
    logic [tcgg_pkg::CHAN_W-1:0] to_c;
    logic signed [8:0]           diff;
    logic [8:0]                  mag;
    logic [AW-1:0]               dividend;
    logic [WW-1:0]               divisor;
    logic                        div_done;
    logic [AW-1:0]               quotient;
    logic signed [SW-1:0]        step_val;

    always_comb begin
        is_right_k = (r_k >= 3'd3);
        ch         = is_right_k ? 2'(r_k - 3'd3) : r_k[1:0];
        from_c     = tcgg_pkg::chan(is_right_k ? r_color_middle : r_color_left, ch);
        to_c       = tcgg_pkg::chan(is_right_k ? r_color_right : r_color_middle, ch);
        diff       = $signed({1'b0, to_c}) - $signed({1'b0, from_c});
        mag        = diff[8] ? 9'(-diff) : 9'(diff);
        dividend   = {mag[7:0], {FRACTION_BITS{1'b0}}};
        divisor    = is_right_k ? right_len : split;
        if (divisor == '0) begin
            step_val = '0;
        end else if (diff[8]) begin
            step_val = -$signed({1'b0, quotient});
        end else begin
            step_val = $signed({1'b0, quotient});
        end
    end

    tcgg_divider #(
        .DVD_W (AW),
        .DVS_W (WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // pixel datapath
    logic [WW-1:0]               col_ext;
    logic                        right;
    logic                        rend;
    logic                        fend;
    logic [AW-1:0]               cur   [NC];
    logic signed [AW+1:0]        sum   [NC];
    logic [AW-1:0]               n_acc [NC];
    logic signed [SW-1:0]        st;

    always_comb begin
        col_ext = WW'(r_col);
        right   = (col_ext >= split);
        rend    = (col_ext == w - WW'(1));
        fend    = rend && (r_row == h - HW'(1));
        for (int k = 0; k < NC; k++) begin
            if (col_ext == split) begin
                cur[k] = {tcgg_pkg::chan(r_color_middle, 2'(k)), {FRACTION_BITS{1'b0}}};
            end else if (col_ext == '0) begin
                cur[k] = {tcgg_pkg::chan(r_color_left, 2'(k)), {FRACTION_BITS{1'b0}}};
            end else begin
                cur[k] = r_acc[k];
            end
            st     = right ? r_step_r[k] : r_step_l[k];
            sum[k] = $signed({2'b00, cur[k]}) + $signed({st[SW-1], st});
            if (sum[k] < 0) begin
                n_acc[k] = '0;
            end else if (sum[k] > $signed({2'b00, {AW{1'b1}}})) begin
                n_acc[k] = {AW{1'b1}};
            end else begin
                n_acc[k] = sum[k][AW-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        in_fire   = 1'b0;
        pix_fire  = 1'b0;
        div_start = 1'b0;
        o_ready   = (r_state == tcgg_pkg::ST_IDLE);
        unique case (r_state)
            tcgg_pkg::ST_IDLE: begin
                if (i_valid) begin
                    in_fire = 1'b1;
                    n_state = frame_start ? tcgg_pkg::ST_DSTART : tcgg_pkg::ST_PIX;
                end
            end
            tcgg_pkg::ST_DSTART: begin
                div_start = 1'b1;
                n_state   = tcgg_pkg::ST_DWAIT;
            end
            tcgg_pkg::ST_DWAIT: begin
                if (div_done) begin
                    n_state = (r_k == 3'd5) ? tcgg_pkg::ST_PIX : tcgg_pkg::ST_DSTART;
                end
            end
            tcgg_pkg::ST_PIX: begin
                if (!r_o_valid || i_ready) begin
                    pix_fire = 1'b1;
                    n_state  = tcgg_pkg::ST_IDLE;
                end
            end
            default: n_state = tcgg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcgg_pkg::ST_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                r_acc[k]    <= '0;
                r_step_l[k] <= '0;
                r_step_r[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_col <= c_col[CW-1:0];
                r_row <= c_row[HW-1:0];
                r_k   <= '0;
            end
            if ((r_state == tcgg_pkg::ST_DWAIT) && div_done) begin
                if (is_right_k) begin
                    r_step_r[ch] <= step_val;
                end else begin
                    r_step_l[ch] <= step_val;
                end
                r_k <= r_k + 3'd1;
            end
            if (pix_fire) begin
                for (int k = 0; k < NC; k++) begin
                    r_acc[k] <= n_acc[k];
                end
                if (rend) begin
                    r_col <= '0;
                    r_row <= fend ? '0 : r_row + HW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_red       <= cur[0][AW-1:FRACTION_BITS];
            r_green     <= cur[1][AW-1:FRACTION_BITS];
            r_blue      <= cur[2][AW-1:FRACTION_BITS];
            r_row_end   <= rend;
            r_frame_end <= fend;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

    // checks
    a_frame_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && frame_start) |=> (r_state == tcgg_pkg::ST_DSTART))
        else $error("frame start request did not start step computation");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == tcgg_pkg::ST_DWAIT))
        else $error("divider finished outside of wait state");

    a_step_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcgg_pkg::ST_DWAIT) |-> (r_k <= 3'd5))
        else $error("step index out of range");

    a_valid_from_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == tcgg_pkg::ST_PIX))
        else $error("pixel shown without pixel computation");

endmodule

### dv/testbench.sv
// Self-checking testbench for the three color gradient generator: predicted pixels vs. DUT output.
`timescale 1ns / 1ps

module testbench;

    localparam int CHAN_W            = tcgg_pkg::CHAN_W;
    localparam int NUM_CHAN          = tcgg_pkg::NUM_CHAN;
    localparam int COLOR_W           = tcgg_pkg::COLOR_W;
    localparam int SIZE_REG_W        = tcgg_pkg::SIZE_REG_W;
    localparam int CFG_INDEX_W       = tcgg_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W        = tcgg_pkg::CFG_DATA_W;
    localparam int MAX_WIDTH_DEF     = tcgg_pkg::MAX_WIDTH_DEF;
    localparam int MAX_HEIGHT_DEF    = tcgg_pkg::MAX_HEIGHT_DEF;
    localparam int FRACTION_BITS_DEF = tcgg_pkg::FRACTION_BITS_DEF;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REQUEST_COUNT = 1100;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [4:0] ALL_REGS  = 5'h1F;
    localparam logic [4:0] SIZE_REGS = 5'((1 << tcgg_pkg::CFG_IMAGE_WIDTH) |
                                          (1 << tcgg_pkg::CFG_IMAGE_HEIGHT));

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              frame_end;
    } t_gradient_pixel;

    class gradient_scoreboard;
        logic [SIZE_REG_W-1:0] width_reg    = tcgg_pkg::WIDTH_RESET;
        logic [SIZE_REG_W-1:0] height_reg   = tcgg_pkg::HEIGHT_RESET;
        logic [COLOR_W-1:0]    left_color   = '0;
        logic [COLOR_W-1:0]    middle_color = '0;
        logic [COLOR_W-1:0]    right_color  = '0;
        int                    column_pos;
        int                    row_pos;
        longint                channel_acc [NUM_CHAN];
        longint                channel_step [2*NUM_CHAN];
        t_gradient_pixel       pixels_due [$];
        int                    mismatches;
        int                    pixels_checked;

        function void set_reg(tcgg_pkg::t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                tcgg_pkg::CFG_IMAGE_WIDTH:  width_reg    = value[SIZE_REG_W-1:0];
                tcgg_pkg::CFG_IMAGE_HEIGHT: height_reg   = value[SIZE_REG_W-1:0];
                tcgg_pkg::CFG_COLOR_LEFT:   left_color   = value[COLOR_W-1:0];
                tcgg_pkg::CFG_COLOR_MIDDLE: middle_color = value[COLOR_W-1:0];
                tcgg_pkg::CFG_COLOR_RIGHT:  right_color  = value[COLOR_W-1:0];
                default: ;
            endcase
        endfunction

        // k = 0 red, 1 green, 2 blue
        function longint channel_of(logic [COLOR_W-1:0] color, int k);
            logic [COLOR_W-1:0] shifted;
            shifted = color >> (CHAN_W * (NUM_CHAN - 1 - k));
            return longint'(shifted[CHAN_W-1:0]);
        endfunction

        function longint ramp_step(longint from, longint to, longint len);
            if (len == 0) return 0;
            return ((to - from) * (longint'(1) << FRACTION_BITS_DEF)) / len;
        endfunction

        function void load_color(logic [COLOR_W-1:0] color);
            for (int k = 0; k < NUM_CHAN; k++)
                channel_acc[k] = channel_of(color, k) * (longint'(1) << FRACTION_BITS_DEF);
        endfunction

        function void add_request(bit restart);
            int                w;
            int                h;
            int                split;
            int                base;
            longint            top;
            longint            acc;
            logic [CHAN_W-1:0] chans [NUM_CHAN];
            t_gradient_pixel   px;
            w = (width_reg == 0) ? 1 :
                (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
            h = (height_reg == 0) ? 1 :
                (height_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(height_reg);
            split = w / 2;
            top = (longint'(256) << FRACTION_BITS_DEF) - 1;

            if (restart) begin
                column_pos = 0;
                row_pos = 0;
            end
            if (column_pos >= w) begin
                column_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) row_pos = 0;

            if (column_pos == 0 && row_pos == 0) begin
                for (int k = 0; k < NUM_CHAN; k++) begin
                    channel_step[k] = ramp_step(channel_of(left_color, k),
                                                channel_of(middle_color, k), split);
                    channel_step[NUM_CHAN + k] = ramp_step(channel_of(middle_color, k),
                                                           channel_of(right_color, k), w - split);
                end
            end

            if (column_pos == split) load_color(middle_color);
            else if (column_pos == 0) load_color(left_color);
            base = (column_pos >= split) ? NUM_CHAN : 0;

            for (int k = 0; k < NUM_CHAN; k++) begin
                acc = channel_acc[k];
                chans[k] = CHAN_W'(acc >> FRACTION_BITS_DEF);
                acc += channel_step[base + k];
                if (acc < 0) acc = 0;
                if (acc > top) acc = top;
                channel_acc[k] = acc;
            end

            px.red       = chans[0];
            px.green     = chans[1];
            px.blue      = chans[2];
            px.row_end   = (column_pos == w - 1);
            px.frame_end = px.row_end && (row_pos == h - 1);
            pixels_due.push_back(px);

            if (px.row_end) begin
                column_pos = 0;
                row_pos = px.frame_end ? 0 : row_pos + 1;
            end else begin
                column_pos++;
            end
        endfunction

        function void check_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                  logic [CHAN_W-1:0] b, logic re, logic fe);
            t_gradient_pixel want;
            pixels_checked++;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: none outstanding, got r=%02h g=%02h b=%02h re=%b fe=%b",
                             pixels_checked, r, g, b, re, fe);
                return;
            end
            want = pixels_due.pop_front();
            if (want.red !== r || want.green !== g || want.blue !== b ||
                want.row_end !== re || want.frame_end !== fe) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"pixel %0d: expected r=%02h g=%02h b=%02h re=%b fe=%b, ",
                              "got r=%02h g=%02h b=%02h re=%b fe=%b"}, pixels_checked,
                             want.red, want.green, want.blue, want.row_end, want.frame_end,
                             r, g, b, re, fe);
            end
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = tcgg_pkg::CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic                   i_restart   = 1'b0;
    logic                   i_ready     = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [CHAN_W-1:0]      o_red;
    logic [CHAN_W-1:0]      o_green;
    logic [CHAN_W-1:0]      o_blue;
    logic                   o_row_end;
    logic                   o_frame_end;

    gradient_scoreboard sb = new();
    int requests_sent;
    int pixels_seen;
    int hold_left;
    bit hold_done;
    bit hold_go;
    int cycles;

    three_color_gradient_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** three_color_gradient_generator: FAILED **");
            $finish;
        end
    end

    // pixel sink: random backpressure, one long hold-off, one stretch always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                sb.check_pixel(o_red, o_green, o_blue, o_row_end, o_frame_end);
                pixels_seen++;
            end
            if (!hold_done && hold_go) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (pixels_seen >= 600 && pixels_seen < 800) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 36);
            end
        end
    end

    task automatic send_pixel(input bit restart);
        if (requests_sent < 600 || requests_sent >= 800) begin
            while ($urandom_range(0, 99) < 36) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.add_request(restart);
        requests_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input tcgg_pkg::t_cfg_index idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input logic [4:0] mask,
                             input logic [SIZE_REG_W-1:0] w, input logic [SIZE_REG_W-1:0] h,
                             input logic [COLOR_W-1:0] l, input logic [COLOR_W-1:0] m,
                             input logic [COLOR_W-1:0] r);
        drain();
        if (mask[tcgg_pkg::CFG_IMAGE_WIDTH])
            write_reg(tcgg_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        if (mask[tcgg_pkg::CFG_IMAGE_HEIGHT])
            write_reg(tcgg_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        if (mask[tcgg_pkg::CFG_COLOR_LEFT])
            write_reg(tcgg_pkg::CFG_COLOR_LEFT, l);
        if (mask[tcgg_pkg::CFG_COLOR_MIDDLE])
            write_reg(tcgg_pkg::CFG_COLOR_MIDDLE, m);
        if (mask[tcgg_pkg::CFG_COLOR_RIGHT])
            write_reg(tcgg_pkg::CFG_COLOR_RIGHT, r);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_REG_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return '0;
        if (r < 8)  return SIZE_REG_W'(1);
        if (r < 12) return SIZE_REG_W'($urandom_range(MAX_WIDTH_DEF + 1, 8191));
        if (r < 16) return SIZE_REG_W'(MAX_WIDTH_DEF);
        if (r < 20) return SIZE_REG_W'($urandom_range(100, MAX_WIDTH_DEF - 1));
        return SIZE_REG_W'($urandom_range(2, 24));
    endfunction

    function automatic logic [SIZE_REG_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 9)  return SIZE_REG_W'($urandom_range(MAX_HEIGHT_DEF + 1, 8191));
        if (r < 12) return SIZE_REG_W'(MAX_HEIGHT_DEF);
        return SIZE_REG_W'($urandom_range(1, 6));
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        logic [COLOR_W-1:0] c;
        c = COLOR_W'($urandom);
        for (int k = 0; k < NUM_CHAN; k++)
            if ($urandom_range(0, 4) == 0)
                c[k*CHAN_W +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return c;
    endfunction

    initial begin
        logic [4:0] mask;
        int         burst;
        bit         lead_restart;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: 500 x 50, all black
        send_pixel(1'b0);

        // width of one: empty left part, every pixel a frame start
        configure(ALL_REGS, 13'd1, 13'd1, 24'h000000, 24'hFFFFFF, 24'h00FF00);
        send_pixel(1'b0);

        // zero sizes taken as one
        configure(SIZE_REGS, 13'd0, 13'd0, '0, '0, '0);
        send_pixel(1'b1);

        // 5 x 2 frame, full wrap plus three pixels into the next frame
        configure(ALL_REGS, 13'd5, 13'd2, 24'hFFFFFF, 24'h000000, 24'hFF00FF);
        for (int n = 0; n < 13; n++) send_pixel(n == 0);

        // new part colors mid-frame with stale steps, pushes accumulators to the rails
        configure(5'((1 << tcgg_pkg::CFG_COLOR_LEFT) | (1 << tcgg_pkg::CFG_COLOR_MIDDLE)),
                  '0, '0, 24'h000000, 24'hFFFFFF, '0);
        repeat (4) send_pixel(1'b0);

        // width shrunk below the current column
        configure(5'(1 << tcgg_pkg::CFG_IMAGE_WIDTH), 13'd2, '0, '0, '0, '0);
        repeat (3) send_pixel(1'b0);

        // height shrunk below the current row
        configure(5'(1 << tcgg_pkg::CFG_IMAGE_HEIGHT), '0, 13'd1, '0, '0, '0);
        send_pixel(1'b0);
        send_pixel(1'b0);

        // sizes above the maximum saturate
        configure(ALL_REGS, 13'd8191, 13'd8191, 24'hFF00FF, 24'h00FF00, 24'h0000FF);
        send_pixel(1'b1);

        // sink holds off while requests keep coming, so the input stalls
        configure(ALL_REGS, 13'd40, 13'd4, 24'h102030, 24'hF0E0D0, 24'h00FF80);
        hold_go = 1'b1;
        for (int n = 0; n < 40; n++) send_pixel(n == 0);

        while (requests_sent < REQUEST_COUNT) begin
            mask = ($urandom_range(0, 3) == 0) ? ALL_REGS : 5'($urandom);
            configure(mask, pick_width(), pick_height(), pick_color(), pick_color(),
                      pick_color());
            burst = $urandom_range(15, 90);
            lead_restart = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < burst; n++)
                send_pixel((n == 0 && lead_restart) || $urandom_range(0, 99) < 4);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** three_color_gradient_generator: PASSED **");
        else
            $display("** three_color_gradient_generator: FAILED **");
        $finish;
    end

endmodule
